// ===== hdl/assert_macros.svh =====
// assertion macros for the aging entry table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define AET_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define AET_ASSERT(label, prop, msg)
`define AET_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== hdl/aet_pkg.sv =====
// package for the aging entry table: types, codes and sizes
package aet_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned SlotW = $clog2(TableEntries);
  localparam int unsigned CntW = SlotW + 1;
  localparam logic [15:0] IncStep = 16'd8;
  localparam logic [15:0] U16Max = 16'hFFFF;

  localparam logic [2:0] CmdInsert = 3'd0;
  localparam logic [2:0] CmdContains = 3'd1;
  localparam logic [2:0] CmdMarkUsed = 3'd2;
  localparam logic [2:0] CmdErase = 3'd3;
  localparam logic [2:0] CmdEvict = 3'd4;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StAbsent = 3'd1;
  localparam logic [2:0] StDup = 3'd2;
  localparam logic [2:0] StFull = 3'd3;
  localparam logic [2:0] StNoEvict = 3'd4;

  // one memory word per slot
  localparam int unsigned EntryW = 64 + 64 + 32 + 16 + 16;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] rect;
    logic [31:0] bearing;
    logic [15:0] epoch;
    logic [15:0] count;
  } entry_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] key;
    logic [15:0] now_epoch;
    logic        ping;
    logic [63:0] rect_in;
    logic [31:0] bearing_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [63:0] key_out;
    logic [63:0] rect_out;
    logic [31:0] bearing_out;
    logic [15:0] use_count;
  } rsp_t;
endpackage

// ===== hdl/aet_ram.sv =====
// generic single-port-write, single-read ram with registered read
module aet_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/aet_age.sv =====
// aging pipeline: decrement by min(count, d*d-d), optional use increment
module aet_age
  import aet_pkg::*;
(
  input  logic        clk_i,
  input  logic [15:0] now_i,
  input  logic [15:0] epoch_i,
  input  logic [15:0] count_i,
  input  logic        use_i,
  output logic [15:0] count_o
);
  logic [15:0] d;
  logic [31:0] sq_d, sq_q;
  logic [15:0] d_q, cnt_q;
  logic        use_q;
  logic [31:0] dec;
  logic [16:0] sum;
  logic [15:0] aged;

  assign d = now_i - epoch_i;
  assign sq_d = 32'(d) * 32'(d);

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
    d_q <= d;
    cnt_q <= count_i;
    use_q <= use_i;
  end

  assign dec = sq_q - 32'(d_q);
  assign aged = (dec > 32'(cnt_q)) ? 16'd0 : cnt_q - dec[15:0];
  assign sum = 17'(aged) + 17'(IncStep);
  always_comb begin
    if (!use_q) begin
      count_o = aged;
    end else if (sum[16]) begin
      count_o = U16Max;
    end else begin
      count_o = sum[15:0];
    end
  end
endmodule

// ===== hdl/aet_ctrl.sv =====
// sequencer: scans slots through the memory and decides each command
module aet_ctrl
  import aet_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  req_t             req_i,
  output logic             busy,
  output logic             done_o,
  output rsp_t             rsp_o,
  output logic             we_o,
  output logic [SlotW-1:0] waddr_o,
  output entry_t           wdata_o,
  output logic [SlotW-1:0] raddr_o,
  input  entry_t           rdata_i,
  output logic [15:0]      age_now_o,
  output logic [15:0]      age_epoch_o,
  output logic [15:0]      age_count_o,
  output logic             age_use_o,
  input  logic [15:0]      age_count_i
);
  typedef enum logic [2:0] {
    SIdle, SScan, SAge, SWrite, SEvAge, SEvWr, SFinal, SDone
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [TableEntries-1:0] valid_q;
  logic [CntW-1:0]   ptr_q;
  logic [SlotW-1:0]  cur_q;
  logic              found_q;
  logic [SlotW-1:0]  hit_q;
  logic              pick_v_q;
  logic [SlotW-1:0]  pick_q;
  logic [15:0]       minc_q;
  logic [63:0]       pkey_q, prect_q;
  entry_t            ent_q;
  rsp_t              rsp_q;
  rsp_t              rsp_d;
  logic              done_q;
  logic              free_v;
  logic [SlotW-1:0]  free_s;
  logic [SlotW-1:0]  ptr_s;

  assign ptr_s = ptr_q[SlotW-1:0];

  always_comb begin
    free_v = 1'b0;
    free_s = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_v = 1'b1;
        free_s = SlotW'(i);
      end
    end
  end

  assign busy = (state_q != SIdle);
  assign done_o = done_q;
  assign rsp_o = rsp_q;
  assign raddr_o = (state_q == SIdle) ? '0 : ptr_s;
  assign age_now_o = req_q.now_epoch;
  assign age_epoch_o = ent_q.epoch;
  assign age_count_o = ent_q.count;
  assign age_use_o = (state_q == SAge);

  always_comb begin
    we_o = 1'b0;
    waddr_o = cur_q;
    wdata_o = ent_q;
    if (state_q == SWrite || state_q == SEvWr) begin
      we_o = 1'b1;
      wdata_o.count = age_count_i;
      if (state_q == SWrite) begin
        wdata_o.epoch = req_q.now_epoch;
      end
    end else if (state_q == SFinal && req_q.cmd == CmdInsert && !found_q && free_v) begin
      we_o = 1'b1;
      waddr_o = free_s;
      wdata_o.key = req_q.key;
      wdata_o.rect = req_q.rect_in;
      wdata_o.bearing = req_q.bearing_in;
      wdata_o.epoch = req_q.now_epoch;
      wdata_o.count = IncStep;
    end
  end

  always_comb begin
    rsp_d = '0;
    unique case (req_q.cmd)
      CmdInsert: begin
        if (found_q) begin
          rsp_d.status = StDup;
        end else if (!free_v) begin
          rsp_d.status = StFull;
        end else begin
          rsp_d.slot = 6'(free_s);
          rsp_d.use_count = IncStep;
        end
      end
      CmdContains, CmdMarkUsed: begin
        if (!found_q) begin
          rsp_d.status = StAbsent;
        end else begin
          rsp_d.slot = 6'(hit_q);
          rsp_d.rect_out = ent_q.rect;
          rsp_d.bearing_out = ent_q.bearing;
          rsp_d.use_count = ent_q.count;
        end
      end
      CmdErase: begin
        if (!found_q) begin
          rsp_d.status = StAbsent;
        end else begin
          rsp_d.slot = 6'(hit_q);
          rsp_d.key_out = ent_q.key;
          rsp_d.rect_out = ent_q.rect;
        end
      end
      CmdEvict: begin
        if (!pick_v_q) begin
          rsp_d.status = StNoEvict;
        end else begin
          rsp_d.slot = 6'(pick_q);
          rsp_d.key_out = pkey_q;
          rsp_d.rect_out = prect_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      valid_q <= '0;
      done_q <= 1'b0;
      ptr_q <= '0;
      found_q <= 1'b0;
      pick_v_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (start) begin
            req_q <= req_i;
            ptr_q <= CntW'(1);
            cur_q <= '0;
            found_q <= 1'b0;
            pick_v_q <= 1'b0;
            minc_q <= U16Max;
            if (req_i.cmd > CmdEvict) begin
              state_q <= SFinal;
            end else begin
              state_q <= SScan;
            end
          end
        end
        SScan: begin
          // rdata holds slot cur_q
          ent_q <= rdata_i;
          if (req_q.cmd == CmdEvict) begin
            if (valid_q[cur_q] && rdata_i.epoch != req_q.now_epoch) begin
              state_q <= SEvAge;
            end else if (cur_q == SlotW'(TableEntries - 1)) begin
              state_q <= SFinal;
            end else begin
              cur_q <= ptr_s;
              ptr_q <= ptr_q + CntW'(1);
            end
          end else if (valid_q[cur_q] && rdata_i.key == req_q.key) begin
            found_q <= 1'b1;
            hit_q <= cur_q;
            if (req_q.cmd == CmdMarkUsed || (req_q.cmd == CmdContains && req_q.ping
                && rdata_i.epoch != req_q.now_epoch)) begin
              state_q <= SAge;
            end else begin
              state_q <= SFinal;
            end
          end else if (cur_q == SlotW'(TableEntries - 1)) begin
            state_q <= SFinal;
          end else begin
            cur_q <= ptr_s;
            ptr_q <= ptr_q + CntW'(1);
          end
        end
        SAge: state_q <= SWrite;
        SWrite: begin
          ent_q.count <= age_count_i;
          ent_q.epoch <= req_q.now_epoch;
          state_q <= SFinal;
        end
        SEvAge: begin
          ptr_q <= CntW'(cur_q) + CntW'(1);
          state_q <= SEvWr;
        end
        SEvWr: begin
          if (minc_q >= age_count_i) begin
            pick_v_q <= 1'b1;
            pick_q <= cur_q;
            minc_q <= age_count_i;
            pkey_q <= ent_q.key;
            prect_q <= ent_q.rect;
          end
          if (age_count_i == 16'd0 || cur_q == SlotW'(TableEntries - 1)) begin
            state_q <= SFinal;
          end else begin
            // raddr is ptr (next slot), data arrives next cycle
            cur_q <= ptr_s;
            ptr_q <= ptr_q + CntW'(1);
            state_q <= SScan;
          end
        end
        SFinal: begin
          rsp_q <= rsp_d;
          if (req_q.cmd == CmdInsert && !found_q && free_v) begin
            valid_q[free_s] <= 1'b1;
          end else if (req_q.cmd == CmdErase && found_q) begin
            valid_q[hit_q] <= 1'b0;
          end else if (req_q.cmd == CmdEvict && pick_v_q) begin
            valid_q[pick_q] <= 1'b0;
          end
          state_q <= SDone;
        end
        SDone: begin
          done_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== hdl/aging_entry_table_with_eviction_unit.sv =====
// top level of the aging entry table with eviction
//  channel  | signals            | handshake
//  command  | start, req_i       | taken when start and not busy
//  result   | done_o, rsp_o      | one-cycle strobe, no backpressure
// a key lookup walks slots one per cycle, at most all 64, then passes SFinal and SDone before the strobe
// a hit that ages also passes SAge and SWrite; evict goes through SEvAge and SEvWr for each aged slot
// the single-port read of the entry memory sets the pace
// reset clears all valid bits at once; the entry memory needs no clearing
// results cannot be stalled; busy stays high until the result strobe
`include "assert_macros.svh"
module aging_entry_table_with_eviction_unit
  import aet_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output rsp_t rsp_o
);
  logic             we;
  logic [SlotW-1:0] waddr, raddr;
  entry_t           wdata, rdata;
  logic [15:0]      a_now, a_ep, a_cnt, a_res;
  logic             a_use;

  aet_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  aet_age u_age (
    .clk_i, .now_i(a_now), .epoch_i(a_ep), .count_i(a_cnt),
    .use_i(a_use), .count_o(a_res)
  );

  aet_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .req_i, .busy, .done_o, .rsp_o,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr),
    .rdata_i(rdata), .age_now_o(a_now), .age_epoch_o(a_ep),
    .age_count_o(a_cnt), .age_use_o(a_use), .age_count_i(a_res)
  );

  `AET_ASSERT(a_done_busy, done_o |-> $past(busy), "result without transaction")
  `AET_ASSERT(a_start_busy, (start && !busy) |=> busy, "transaction not taken")
  `AET_ASSERT(a_done_idle, done_o |-> !busy, "busy during result")
  `AET_ASSERT_RST(a_rst_quiet, !rst_ni |-> !done_o, "result during reset")
endmodule
